// ===== sv/led_matrix_row_scanner_top_assert.svh =====
// Assertion macros for the scanner RTL; lms_back includes them.
`ifndef LED_MATRIX_ROW_SCANNER_TOP_ASSERT_SVH
`define LED_MATRIX_ROW_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lms_pkg.sv =====
package lms_pkg;

    localparam int ROWS_DEF        = 8;
    localparam int COLS_DEF        = 8;
    localparam int DUTY_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Field layout of the request tdata word.
    localparam int IN_COL_LSB      = 0;
    localparam int IN_ROW_LSB      = 3;
    localparam int IN_RED_LSB      = 6;
    localparam int IN_GREEN_LSB    = 22;
    localparam int IN_BLUE_LSB     = 38;
    localparam int IDX_W           = 3;
    localparam int DUTY_W          = 16;
    localparam int TDATA_W         = 56;

    localparam logic KIND_COLUMN   = 1'b0;
    localparam logic KIND_ACK      = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_FILL = 2'd2,
        FUNC_SWAP = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_OUT,
        ST_FILL,
        ST_ACK
    } back_state_t;

    typedef struct packed {
        func_t              func;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
    } cmd_hdr_t;

    typedef struct packed {
        logic               kind;
        logic               last;
        logic               swap_done;
        logic [DUTY_W-1:0]  blue_duty;
        logic [DUTY_W-1:0]  green_duty;
        logic [DUTY_W-1:0]  red_duty;
        logic [IDX_W-1:0]   column;
        logic [IDX_W-1:0]   active_row;
    } result_t;

    // Reduces a 3-bit index modulo m (m >= 2) by repeated compare and subtract.
    function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] v,
                                                    input logic [5:0] m);
        logic [5:0] r;
        r = {3'b000, v};
        for (int i = 0; i < 3; i++)
        begin
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[IDX_W-1:0];
    endfunction

endpackage

// ===== sv/lms_ram.sv =====
module lms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lms_front.sv =====
module lms_front
    import lms_pkg::*;
#(
    parameter int ROWS      = ROWS_DEF,
    parameter int COLS      = COLS_DEF,
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [TDATA_W-1:0]       s_tdata,
    input  logic [1:0]               s_tuser,
    input  logic                     clearing,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output cmd_hdr_t                 cmd_hdr,
    output logic [3*DUTY_BITS-1:0]   cmd_pix
);

    localparam int PW  = 3 * DUTY_BITS;
    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_hdr_t          q_hdr_reg [QUEUE_DEPTH];
    logic [PW-1:0]     q_pix_reg [QUEUE_DEPTH];
    logic [QPW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]    count_reg, count_next;
    logic              push, pop;
    cmd_hdr_t          in_hdr;
    logic [PW-1:0]     in_pix;

    // Classify the request: index wrap and duty masking happen here.
    always_comb
    begin
        in_hdr.func = func_t'(s_tuser);
        in_hdr.col  = wrap_index(s_tdata[IN_COL_LSB +: IDX_W], 6'(COLS));
        in_hdr.row  = wrap_index(s_tdata[IN_ROW_LSB +: IDX_W], 6'(ROWS));
        in_pix      = {s_tdata[IN_BLUE_LSB +: DUTY_BITS],
                       s_tdata[IN_GREEN_LSB +: DUTY_BITS],
                       s_tdata[IN_RED_LSB +: DUTY_BITS]};
    end

    assign s_tready  = !clearing && (count_reg != QCW'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_hdr   = q_hdr_reg[rd_ptr_reg];
    assign cmd_pix   = q_pix_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_hdr_reg[wr_ptr_reg] <= in_hdr;
            q_pix_reg[wr_ptr_reg] <= in_pix;
        end
    end

endmodule

// ===== sv/lms_back.sv =====
`include "led_matrix_row_scanner_top_assert.svh"

module lms_back
    import lms_pkg::*;
#(
    parameter int ROWS      = ROWS_DEF,
    parameter int COLS      = COLS_DEF,
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  cmd_hdr_t                 cmd_hdr,
    input  logic [3*DUTY_BITS-1:0]   cmd_pix,
    output logic                     clearing,
    output logic                     out_valid,
    input  logic                     out_ready,
    output result_t                  out_res
);

    localparam int PIX   = ROWS * COLS;
    localparam int DEPTH = 2 * PIX;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(PIX);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int PW    = 3 * DUTY_BITS;

    back_state_t     state_reg, state_next;
    logic [RW-1:0]   scan_row_reg, scan_row_next;
    logic            front_reg, front_next;
    logic            busy_reg, busy_next;
    logic            waiting_reg, waiting_next;
    logic [AW-1:0]   clear_cnt_reg, clear_cnt_next;
    logic [OW-1:0]   fill_cnt_reg, fill_cnt_next;
    logic [CW-1:0]   col_cnt_reg, col_cnt_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_res_reg, out_res_next;
    logic            tick_front_reg, tick_front_next;
    logic            tick_done_reg, tick_done_next;
    logic [PW-1:0]   fill_pix_reg, fill_pix_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [PW-1:0]   ram_wdata, ram_rdata;

    logic            out_free, load_out;
    logic            tick_last, fill_last, clear_last;
    logic [RW-1:0]   row_adv;

    function automatic logic [AW-1:0] buf_addr(input logic sel, input logic [AW-1:0] off);
        return off + (sel ? AW'(PIX) : '0);
    endfunction

    lms_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign tick_last  = (col_cnt_reg == CW'(COLS - 1));
    assign fill_last  = (fill_cnt_reg == OW'(PIX - 1));
    assign clear_last = (clear_cnt_reg == AW'(DEPTH - 1));
    assign row_adv    = (scan_row_reg == RW'(ROWS - 1)) ? '0 : scan_row_reg + 1'b1;
    assign clearing   = (state_reg == ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_hdr.func)
                        FUNC_TICK: state_next = ST_TICK_RD;
                        FUNC_FILL: state_next = ST_FILL;
                        FUNC_SET,
                        FUNC_SWAP: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_RD:
            begin
                state_next = ST_TICK_OUT;
            end
            ST_TICK_OUT:
            begin
                if (out_free && tick_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        load_out        = 1'b0;
        scan_row_next   = scan_row_reg;
        front_next      = front_reg;
        busy_next       = busy_reg;
        waiting_next    = waiting_reg;
        clear_cnt_next  = clear_cnt_reg;
        fill_cnt_next   = fill_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        tick_front_next = tick_front_reg;
        tick_done_next  = tick_done_reg;
        fill_pix_next   = fill_pix_reg;

        // Acknowledgement by default; the scan state overrides it for columns.
        out_res_next            = '0;
        out_res_next.kind       = KIND_ACK;
        out_res_next.last       = 1'b1;
        out_res_next.active_row = IDX_W'(scan_row_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = clear_cnt_reg;
                clear_cnt_next = clear_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_hdr.func)
                        FUNC_TICK:
                        begin
                            cmd_ready       = 1'b1;
                            scan_row_next   = row_adv;
                            tick_front_next = front_reg;
                            tick_done_next  = 1'b0;
                            col_cnt_next    = '0;
                            if (row_adv == '0)
                            begin
                                busy_next = 1'b1;
                            end
                            if (row_adv == RW'(ROWS - 1))
                            begin
                                busy_next = waiting_reg;
                                if (waiting_reg)
                                begin
                                    front_next     = !front_reg;
                                    waiting_next   = 1'b0;
                                    tick_done_next = 1'b1;
                                end
                            end
                        end
                        FUNC_SET:
                        begin
                            if (out_free)
                            begin
                                cmd_ready = 1'b1;
                                load_out  = 1'b1;
                                ram_we    = 1'b1;
                                ram_wdata = cmd_pix;
                                ram_waddr = buf_addr(!front_reg,
                                                     AW'(cmd_hdr.row) * AW'(COLS)
                                                     + AW'(cmd_hdr.col));
                            end
                        end
                        FUNC_FILL:
                        begin
                            cmd_ready     = 1'b1;
                            fill_pix_next = cmd_pix;
                            fill_cnt_next = '0;
                        end
                        FUNC_SWAP:
                        begin
                            if (out_free)
                            begin
                                cmd_ready = 1'b1;
                                load_out  = 1'b1;
                                if (!busy_reg)
                                begin
                                    front_next             = !front_reg;
                                    busy_next              = 1'b1;
                                    waiting_next           = 1'b0;
                                    out_res_next.swap_done = 1'b1;
                                end
                                else
                                begin
                                    waiting_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_TICK_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = buf_addr(tick_front_reg,
                                     AW'(scan_row_reg) * AW'(COLS) + AW'(col_cnt_reg));
            end
            ST_TICK_OUT:
            begin
                if (out_free)
                begin
                    load_out                = 1'b1;
                    out_res_next.kind       = KIND_COLUMN;
                    out_res_next.last       = tick_last;
                    out_res_next.swap_done  = tick_done_reg;
                    out_res_next.column     = IDX_W'(col_cnt_reg);
                    out_res_next.red_duty   = DUTY_W'(ram_rdata[0 +: DUTY_BITS]);
                    out_res_next.green_duty = DUTY_W'(ram_rdata[DUTY_BITS +: DUTY_BITS]);
                    out_res_next.blue_duty  = DUTY_W'(ram_rdata[2*DUTY_BITS +: DUTY_BITS]);
                    if (!tick_last)
                    begin
                        // Fetch the next column while this one goes out.
                        col_cnt_next = col_cnt_reg + 1'b1;
                        ram_re       = 1'b1;
                        ram_raddr    = buf_addr(tick_front_reg,
                                                AW'(scan_row_reg) * AW'(COLS)
                                                + AW'(col_cnt_reg) + AW'(1));
                    end
                end
            end
            ST_FILL:
            begin
                ram_we        = 1'b1;
                ram_wdata     = fill_pix_reg;
                ram_waddr     = buf_addr(!front_reg, AW'(fill_cnt_reg));
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
            ST_ACK:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_row_reg  <= '0;
            front_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            waiting_reg   <= 1'b0;
            clear_cnt_reg <= '0;
            fill_cnt_reg  <= '0;
            col_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_row_reg  <= scan_row_next;
            front_reg     <= front_next;
            busy_reg      <= busy_next;
            waiting_reg   <= waiting_next;
            clear_cnt_reg <= clear_cnt_next;
            fill_cnt_reg  <= fill_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_front_reg <= tick_front_next;
        tick_done_reg  <= tick_done_next;
        fill_pix_reg   <= fill_pix_next;
        if (load_out)
        begin
            out_res_reg <= out_res_next;
        end
    end

    `LMS_ASSERT_NOW(ast_wait_needs_busy, clk, rst_n, waiting_reg, busy_reg, "swap waiting outside a busy frame")
    `LMS_ASSERT_NOW(ast_no_write_in_scan, clk, rst_n, (state_reg == ST_TICK_RD || state_reg == ST_TICK_OUT), !ram_we, "frame store written during a row scan")
    `LMS_ASSERT_NOW(ast_quiet_while_clearing, clk, rst_n, clearing, (!out_valid_reg && !cmd_ready), "activity during the clearing pass")
    `LMS_ASSERT_NEXT(ast_tick_moves_row, clk, rst_n, (state_reg == ST_IDLE && cmd_valid && cmd_hdr.func == FUNC_TICK), (scan_row_reg != $past(scan_row_reg)), "tick did not advance the row")

endmodule

// ===== sv/led_matrix_row_scanner_top.sv =====
// Channel   Dir  Beat                         Payload
// s_*       in   request: tick/set/fill/swap  tuser = func, tdata = pixel position and color
// m_*       out  result: column value or ack  tuser = kind, tdata = row/column/duties/swap flag
//
// A tick in the executor is a dispatch, a first store read, then one column result per
// cycle while the result register is free. Set and swap finish at dispatch; a fill writes
// every back-buffer entry and then returns an ack. The single write and single read port
// of the frame store set these steps. After reset a clearing pass writes zero to all
// 2*ROWS*COLS entries; no request is accepted until it ends. A two-entry command queue takes
// requests while the executor is busy, and the result register holds a result for m_tready.
module led_matrix_row_scanner_top
    import lms_pkg::*;
#(
    parameter int ROWS      = ROWS_DEF,
    parameter int COLS      = COLS_DEF,
    parameter int DUTY_BITS = DUTY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // col_x[2:0], row_y[5:3], red_in[21:6], green_in[37:22], blue_in[53:38], zero[55:54]
    input  logic [TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // active_row[2:0], column[5:3], red_duty[21:6], green_duty[37:22],
    // blue_duty[53:38], swap_done[54], zero[55]
    output logic [TDATA_W-1:0]  m_tdata,
    // kind[0]
    output logic                m_tuser,
    output logic                m_tlast
);

    // Front side: accepts requests, wraps the pixel indices, masks the duty values
    // and queues the classified command.
    logic                    cmd_valid;
    logic                    cmd_ready;
    cmd_hdr_t                cmd_hdr;
    logic [3*DUTY_BITS-1:0]  cmd_pix;
    logic                    clearing;
    result_t                 res;

    lms_front #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .DUTY_BITS (DUTY_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_hdr   (cmd_hdr),
        .cmd_pix   (cmd_pix)
    );

    // Back side: owns the frame store and the scan state, runs one command at a time.
    lms_back #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_hdr   (cmd_hdr),
        .cmd_pix   (cmd_pix),
        .clearing  (clearing),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result register onto the master-side bus.
    assign m_tdata = {1'b0, res.swap_done, res.blue_duty, res.green_duty, res.red_duty,
                      res.column, res.active_row};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ===== verif/tb.sv =====
// Testbench for led_matrix_row_scanner_top.
//
// A queue of requests is built at time zero: first a short directed
// sequence that walks the scanner through its special cases, then about
// three hundred random requests. A clocked driver presents them on the
// s_* stream in bursts with random gaps. A clocked receiver stalls m_tready
// in patterns that change over the run. Every accepted request goes through
// an independent model of the scanner. The model keeps its own copy of both
// frame buffers, the scanned row and the swap flags, and it queues the
// result beats that the request must produce. The monitor compares each
// accepted result beat, field by field, with the oldest queued beat.
module tb;
    import lms_pkg::*;

    localparam int NROWS        = ROWS_DEF;
    localparam int NCOLS        = COLS_DEF;
    localparam int BUF_PIXELS   = NROWS * NCOLS;
    localparam int RANDOM_COUNT = 300;
    // A fill keeps the executor busy while it writes every back-buffer entry, which is the
    // longest stretch in which the block can still owe us anything.
    localparam int DRAIN_CYCLES = 2 * BUF_PIXELS + 20;
    // The slowest correct run stays well under this limit, even with the clearing
    // pass, every fill, and the sparsest receiver pattern.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // One request as the driver sees it, before it is packed onto the bus.
    typedef struct {
        func_t              func;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic [DUTY_W-1:0]  red;
        logic [DUTY_W-1:0]  green;
        logic [DUTY_W-1:0]  blue;
    } scan_request_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_COMB
    } rx_pattern_t;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]          s_tuser  = FUNC_TICK;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    led_matrix_row_scanner_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Model state of the scanner. The pixels are stored as {blue, green, red},
    // and each one is indexed by {buffer, row, column}.
    logic [3*DUTY_W-1:0] pixel_store [0:2*BUF_PIXELS-1];
    int                  scan_row;
    logic                front_buf;
    logic                frame_busy;
    logic                swap_pending;

    // Requests not yet presented to the block, and result beats that are owed.
    scan_request_t       request_backlog [$];
    result_t             scan_results_due [$];
    scan_request_t       current_request;

    int                  cycle_count     = 0;
    int                  request_total   = 0;
    int                  accepted_count  = 0;
    int                  beats_checked   = 0;
    int                  mismatch_count  = 0;
    int                  ticks_seen      = 0;
    int                  sets_seen       = 0;
    int                  fills_seen      = 0;
    int                  swaps_seen      = 0;
    int                  swaps_immediate = 0;
    int                  swaps_deferred  = 0;
    bit                  timed_out       = 1'b0;

    // Driver and receiver pacing.
    int                  gap_left   = 0;
    int                  burst_left = 0;
    rx_pattern_t         rx_pattern = RX_OPEN;
    int                  rx_left    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Builds one result beat. Acknowledgements carry zero column and duties.
    function automatic result_t scan_beat(input logic kind, input int col,
                                          input logic [3*DUTY_W-1:0] pix,
                                          input logic done, input logic last);
        result_t beat;
        beat.kind       = kind;
        beat.active_row = scan_row[IDX_W-1:0];
        beat.column     = col[IDX_W-1:0];
        beat.red_duty   = pix[DUTY_W-1:0];
        beat.green_duty = pix[2*DUTY_W-1:DUTY_W];
        beat.blue_duty  = pix[3*DUTY_W-1:2*DUTY_W];
        beat.swap_done  = done;
        beat.last       = last;
        return beat;
    endfunction

    // Applies one accepted request to the model and queues the beats it owes.
    task automatic scanner_apply(input scan_request_t req);
        logic [3*DUTY_W-1:0] row_pixels [0:NCOLS-1];
        logic [3*DUTY_W-1:0] color;
        logic                back_buf;
        logic                done;
        int                  base;
        int                  x;
        int                  y;
        color    = {req.blue, req.green, req.red};
        back_buf = ~front_buf;
        done     = 1'b0;
        case (req.func)
            FUNC_TICK:
            begin
                ticks_seen++;
                scan_row = (scan_row + 1) % NROWS;
                if (scan_row == 0)
                begin
                    frame_busy = 1'b1;
                end
                // The row is latched from the front buffer before any exchange.
                base = int'(front_buf) * BUF_PIXELS + scan_row * NCOLS;
                for (int i = 0; i < NCOLS; i++)
                begin
                    row_pixels[i] = pixel_store[base + i];
                end
                // When the last row is loaded, the frame ends and a held swap fires.
                if (scan_row == NROWS - 1)
                begin
                    frame_busy = 1'b0;
                    if (swap_pending)
                    begin
                        front_buf    = ~front_buf;
                        frame_busy   = 1'b1;
                        swap_pending = 1'b0;
                        done         = 1'b1;
                        swaps_deferred++;
                    end
                end
                for (int i = 0; i < NCOLS; i++)
                begin
                    scan_results_due.push_back(scan_beat(KIND_COLUMN, i, row_pixels[i], done,
                                                         i == NCOLS - 1));
                end
            end
            FUNC_SET:
            begin
                sets_seen++;
                x = int'(req.col) % NCOLS;
                y = int'(req.row) % NROWS;
                pixel_store[int'(back_buf) * BUF_PIXELS + y * NCOLS + x] = color;
                scan_results_due.push_back(scan_beat(KIND_ACK, 0, '0, 1'b0, 1'b1));
            end
            FUNC_FILL:
            begin
                fills_seen++;
                for (int i = 0; i < BUF_PIXELS; i++)
                begin
                    pixel_store[int'(back_buf) * BUF_PIXELS + i] = color;
                end
                scan_results_due.push_back(scan_beat(KIND_ACK, 0, '0, 1'b0, 1'b1));
            end
            default:
            begin
                // A swap. When no frame is in flight, it takes effect at once.
                // Otherwise it is held, and a repeated swap only re-arms the same flag.
                swaps_seen++;
                if (!frame_busy)
                begin
                    front_buf    = ~front_buf;
                    frame_busy   = 1'b1;
                    swap_pending = 1'b0;
                    done         = 1'b1;
                    swaps_immediate++;
                end
                else
                begin
                    swap_pending = 1'b1;
                end
                scan_results_due.push_back(scan_beat(KIND_ACK, 0, '0, done, 1'b1));
            end
        endcase
    endtask

    task automatic queue_request(input func_t func, input int col, input int row,
                                 input int red, input int green, input int blue);
        scan_request_t req;
        req.func  = func;
        req.col   = col[IDX_W-1:0];
        req.row   = row[IDX_W-1:0];
        req.red   = red[DUTY_W-1:0];
        req.green = green[DUTY_W-1:0];
        req.blue  = blue[DUTY_W-1:0];
        request_backlog.push_back(req);
    endtask

    // Duty values lean on the extremes now and then, and are uniform otherwise.
    function automatic int pick_duty();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
        begin
            return 0;
        end
        if (roll == 1)
        begin
            return 16'hffff;
        end
        return $urandom_range(0, 16'hffff);
    endfunction

    // Sender: it presents the backlog in bursts of random length and inserts
    // random gaps after a burst. A request that is not yet taken is held unchanged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin : drive_step
            scan_request_t nxt;
            if (s_tvalid && s_tready)
            begin
                scanner_apply(current_request);
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (request_backlog.size() != 0)
                begin
                    nxt = request_backlog.pop_front();
                    current_request <= nxt;
                    s_tvalid        <= 1'b1;
                    s_tuser         <= nxt.func;
                    s_tdata         <= {2'b00, nxt.blue, nxt.green, nxt.red, nxt.row, nxt.col};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        // About a quarter of the bursts run on with no gap at all.
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: it switches now and then between always ready, a coin flip,
    // mostly stalled, and a fixed comb pattern taken from the cycle count.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            rx_pattern <= RX_OPEN;
            rx_left    <= 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
                rx_left    <= $urandom_range(20, 150);
            end
            else
            begin
                rx_left <= rx_left - 1;
            end
            case (rx_pattern)
                RX_OPEN:   m_tready <= 1'b1;
                RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= cycle_count[1] ^ cycle_count[3];
            endcase
        end
    end

    // Monitor: each accepted result beat is checked against the oldest owed beat.
    always @(posedge clk)
    begin : check_beat
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind       = m_tuser;
            got.last       = m_tlast;
            got.active_row = m_tdata[2:0];
            got.column     = m_tdata[5:3];
            got.red_duty   = m_tdata[21:6];
            got.green_duty = m_tdata[37:22];
            got.blue_duty  = m_tdata[53:38];
            got.swap_done  = m_tdata[54];
            if (scan_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                begin
                    $display("[%0d] unexpected result beat: kind=%0b row=%0d col=%0d", cycle_count,
                             got.kind, got.active_row, got.column);
                end
            end
            else
            begin
                want = scan_results_due.pop_front();
                beats_checked++;
                if (got.kind !== want.kind || got.last !== want.last
                    || got.active_row !== want.active_row || got.column !== want.column
                    || got.red_duty !== want.red_duty || got.green_duty !== want.green_duty
                    || got.blue_duty !== want.blue_duty || got.swap_done !== want.swap_done)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("[%0d] beat %0d mismatch", cycle_count, beats_checked);
                        $display("  expected kind=%0b row=%0d col=%0d r=%h g=%h b=%h swap=%0b last=%0b",
                                 want.kind, want.active_row, want.column, want.red_duty,
                                 want.green_duty, want.blue_duty, want.swap_done, want.last);
                        $display("  actual   kind=%0b row=%0d col=%0d r=%h g=%h b=%h swap=%0b last=%0b",
                                 got.kind, got.active_row, got.column, got.red_duty,
                                 got.green_duty, got.blue_duty, got.swap_done, got.last);
                    end
                end
            end
        end
    end

    initial
    begin
        int roll;
        for (int i = 0; i < 2 * BUF_PIXELS; i++)
        begin
            pixel_store[i] = '0;
        end
        scan_row     = 0;
        front_buf    = 1'b0;
        frame_busy   = 1'b0;
        swap_pending = 1'b0;

        // Directed part. Right after reset, a tick scans the cleared front buffer.
        queue_request(FUNC_TICK, 7, 7, 16'hffff, 16'hffff, 16'hffff);
        // Opposite corners of the back buffer get both color extremes.
        queue_request(FUNC_SET, 7, 7, 16'hffff, 16'hffff, 16'hffff);
        queue_request(FUNC_SET, 0, 0, 16'h0000, 16'h0000, 16'h0000);
        queue_request(FUNC_SET, 2, 6, 16'h1234, 16'h5678, 16'h9abc);
        // No frame is in flight yet, so this swap takes effect at once.
        queue_request(FUNC_SWAP, 0, 0, 0, 0, 0);
        // Scan rows 2 to 7 of the new front buffer. Row 7 ends the frame.
        for (int r = 0; r < 6; r++)
        begin
            queue_request(FUNC_TICK, r, 7 - r, 0, 0, 0);
        end
        // Fill the new back buffer, then start a frame with the tick to row 0.
        queue_request(FUNC_FILL, 5, 3, 16'ha5a5, 16'h5a5a, 16'hffff);
        queue_request(FUNC_TICK, 0, 0, 0, 0, 0);
        // A swap in a busy frame is held, and a second swap is absorbed.
        queue_request(FUNC_SWAP, 7, 7, 16'hffff, 16'hffff, 16'hffff);
        queue_request(FUNC_SWAP, 0, 0, 0, 0, 0);
        // A write while the swap waits still lands in the current back buffer.
        queue_request(FUNC_SET, 4, 0, 16'h0f0f, 16'hf0f0, 16'h00ff);
        // Rows 1 to 7. The held exchange fires on the tick that loads row 7.
        for (int r = 0; r < 7; r++)
        begin
            queue_request(FUNC_TICK, 0, 0, 0, 0, 0);
        end
        // Show row 0 of the freshly swapped buffer.
        queue_request(FUNC_TICK, 0, 0, 0, 0, 0);

        // Random part: mostly ticks and pixel writes so that the content written
        // keeps showing up in scans, with swaps in every phase of the frame and
        // an occasional fill. Unused fields of ticks and swaps carry noise.
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            roll = $urandom_range(0, 99);
            queue_request(roll < 45 ? FUNC_TICK : roll < 77 ? FUNC_SET :
                          roll < 82 ? FUNC_FILL : FUNC_SWAP,
                          $urandom_range(0, 7), $urandom_range(0, 7),
                          pick_duty(), pick_duty(), pick_duty());
        end
        request_total = request_backlog.size();

        // The block runs its clearing pass after reset, and the driver simply
        // waits for s_tready to come up.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                while (accepted_count < request_total)
                begin
                    @(posedge clk);
                end
                while (scan_results_due.size() != 0)
                begin
                    @(posedge clk);
                end
                // Leave room for any stray beat to show up after the last one owed.
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT)
                begin
                    @(posedge clk);
                end
                timed_out = 1'b1;
            end
        join_any

        if (timed_out)
        begin
            $display("Timeout at cycle %0d: %0d of %0d requests accepted", cycle_count,
                     accepted_count, request_total);
        end
        if (scan_results_due.size() != 0)
        begin
            $display("%0d result beats never arrived", scan_results_due.size());
        end
        $display("Covered %0d requests: %0d ticks, %0d pixel writes, %0d fills, %0d swaps",
                 accepted_count, ticks_seen, sets_seen, fills_seen, swaps_seen);
        $display("Checked %0d result beats; %0d swaps at once, %0d held to frame end; %0d errors",
                 beats_checked, swaps_immediate, swaps_deferred, mismatch_count);
        if (!timed_out && mismatch_count == 0 && scan_results_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
